FILE: src/blr_pkg.sv
// Shared types and constants for the Bresenham line rasterizer.
// No dependencies; every other file imports this package.
`default_nettype none

package blr_pkg;

   // Pixel count cap of one line command
   localparam int MAX_SIDE = 64;
   localparam int CNT_W    = $clog2(MAX_SIDE);

   // Field widths
   localparam int COORD_W = 6;
   localparam int SYM_W   = 8;
   localparam int CSR_W   = 7;
   localparam int CSR_IDX_W = 2;
   localparam int ERR_W   = 8;
   // Working width for the doubled error term and its compares
   localparam int CALC_W  = ERR_W + 2;

   // Configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CANVAS_HEIGHT = 2'd1;
   localparam logic [CSR_W-1:0]     CANVAS_RESET      = 7'd64;

   // Line command request
   typedef struct packed {
      logic [COORD_W-1:0] start_x;
      logic [COORD_W-1:0] start_y;
      logic [COORD_W-1:0] end_x;
      logic [COORD_W-1:0] end_y;
      logic [SYM_W-1:0]   draw_symbol;
   } req_type;

   // One emitted pixel
   typedef struct packed {
      logic [COORD_W-1:0] pixel_x;
      logic [COORD_W-1:0] pixel_y;
      logic [SYM_W-1:0]   pixel_symbol;
      logic               out_of_canvas;
      logic               last;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;   // capture a new command, present its first pixel
      logic step;   // advance to the next pixel
   } dp_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic fin;    // presented pixel ends the run
   } dp_status_type;

endpackage

`default_nettype wire

FILE: src/blr_ctrl.sv
// Controller state machine of the line rasterizer: request and pixel handshakes.
// Depends on blr_pkg for the command and status structs.
`default_nettype none

module blr_ctrl import blr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output dp_cmd_type         cmd,
   input  wire dp_status_type status
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_EMIT = 1'b1;

   logic state_ff;
   logic state_in;
   logic rsp_take;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_take  = rsp_valid && !rsp_stall;

   // Next state and datapath commands
   always_comb begin
      state_in = state_ff;
      cmd.load = 1'b0;
      cmd.step = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_take) begin
               if (status.fin) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.step = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

FILE: src/blr_datapath.sv
// Datapath of the line rasterizer: canvas registers, Bresenham walk, pixel output from the walk registers.
// Depends on blr_pkg for types and widths.
`default_nettype none

module blr_datapath import blr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata,
   input  wire req_type              req_data,
   input  wire dp_cmd_type           cmd,
   output dp_status_type             status,
   output rsp_type                   rsp_data
);

   logic [CSR_W-1:0]   canvas_w_ff;
   logic [CSR_W-1:0]   canvas_h_ff;

   logic [COORD_W-1:0] cur_x_ff, cur_x_in;
   logic [COORD_W-1:0] cur_y_ff, cur_y_in;
   logic [ERR_W-1:0]   err_ff, err_in;
   logic [COORD_W-1:0] dx_ff, dx_in;
   logic [COORD_W-1:0] dy_ff, dy_in;
   logic [1:0]         signs_ff, signs_in;   // bit 0: x steps down, bit 1: y steps down
   logic [COORD_W-1:0] end_x_ff, end_y_ff;
   logic [SYM_W-1:0]   sym_ff;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(MAX_SIDE - 1);

   logic signed [CALC_W-1:0] err_ext, e2, dx_ext, dy_ext, err_calc;
   logic                     move_x, move_y;
   logic                     outside, at_end;

   // Canvas size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         canvas_w_ff <= CANVAS_RESET;
         canvas_h_ff <= CANVAS_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CANVAS_WIDTH:  canvas_w_ff <= csr_wdata;
            CSR_CANVAS_HEIGHT: canvas_h_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Bresenham step decision
   assign err_ext = CALC_W'(signed'(err_ff));
   assign e2      = err_ext <<< 1;
   assign dx_ext  = signed'(CALC_W'(dx_ff));
   assign dy_ext  = signed'(CALC_W'(dy_ff));
   assign move_x  = (e2 > -dy_ext);
   assign move_y  = (e2 < dx_ext);

   always_comb begin
      err_calc = err_ext;
      if (move_x) begin
         err_calc = err_calc - dy_ext;
      end
      if (move_y) begin
         err_calc = err_calc + dx_ext;
      end
   end

   // Next walk state: load a new command or take one step
   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      err_in   = err_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      signs_in = signs_ff;
      cnt_in   = cnt_ff;
      if (cmd.load) begin
         cur_x_in = req_data.start_x;
         cur_y_in = req_data.start_y;
         dx_in    = (req_data.end_x > req_data.start_x) ?
                    req_data.end_x - req_data.start_x : req_data.start_x - req_data.end_x;
         dy_in    = (req_data.end_y > req_data.start_y) ?
                    req_data.end_y - req_data.start_y : req_data.start_y - req_data.end_y;
         err_in   = ERR_W'(signed'({1'b0, dx_in}) - signed'({1'b0, dy_in}));
         signs_in = {!(req_data.start_y < req_data.end_y),
                     !(req_data.start_x < req_data.end_x)};
         cnt_in   = '0;
      end else if (cmd.step) begin
         if (move_x) begin
            cur_x_in = signs_ff[0] ? cur_x_ff - 1'b1 : cur_x_ff + 1'b1;
         end
         if (move_y) begin
            cur_y_in = signs_ff[1] ? cur_y_ff - 1'b1 : cur_y_ff + 1'b1;
         end
         err_in = ERR_W'(err_calc);
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff <= cur_x_in;
      cur_y_ff <= cur_y_in;
      err_ff   <= err_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      signs_ff <= signs_in;
      cnt_ff   <= cnt_in;
      if (cmd.load) begin
         end_x_ff <= req_data.end_x;
         end_y_ff <= req_data.end_y;
         sym_ff   <= req_data.draw_symbol;
      end
   end

   // Canvas check and end of run
   assign outside = !(({1'b0, cur_x_ff} < canvas_w_ff) && ({1'b0, cur_y_ff} < canvas_h_ff));
   assign at_end  = (cur_x_ff == end_x_ff) && (cur_y_ff == end_y_ff);
   assign status.fin = outside || at_end || (cnt_ff == LAST_CNT);

   // Pixel presented straight from the walk registers
   assign rsp_data.pixel_x       = cur_x_ff;
   assign rsp_data.pixel_y       = cur_y_ff;
   assign rsp_data.pixel_symbol  = sym_ff;
   assign rsp_data.out_of_canvas = outside;
   assign rsp_data.last          = status.fin;

endmodule

`default_nettype wire

FILE: src/bresenham_line_rasterizer.sv
// Bresenham line rasterizer: one line command in, one pixel per cycle out while the result side does not stall.
// The first pixel is offered in the cycle after the request is accepted.
// No new command is taken until the last pixel of the current one is accepted;
// the walk loop in the datapath advances one pixel per accepted result.
// Reset: synchronous, active high; returns to idle, canvas registers to 64 x 64.
// Depends on blr_pkg, blr_ctrl and blr_datapath.
`default_nettype none

module bresenham_line_rasterizer import blr_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   blr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   blr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

FILE: tb/sv/bresenham_line_rasterizer_test.sv
`timescale 1ns / 1ps
// Self-checking bench for bresenham_line_rasterizer: directed table, then random lines over
// several canvas sizes, each pixel checked by an in-bench Bresenham walk or a typed pixel.
// Depends on blr_pkg and the rasterizer RTL.

module bresenham_line_rasterizer_test;
   import blr_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int MAX_WAIT    = 6;
   // Index with no register behind it; writes there must be ignored
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   // One row of the directed plan: canvas to use, the request, and an optional typed pixel
   typedef struct packed {
      logic [CSR_W-1:0] width;
      logic [CSR_W-1:0] height;
      req_type          cmd;
      logic             typed;
      rsp_type          want;
   } line_row_type;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   // Shadow of the canvas registers
   logic [CSR_W-1:0] canvas_w = CANVAS_RESET;
   logic [CSR_W-1:0] canvas_h = CANVAS_RESET;

   rsp_type      expected_pixels[$];
   line_row_type line_plan[$];
   int           fail_count  = 0;
   int           cycle_count = 0;
   bit           req_calm    = 1'b0;
   bit           rsp_calm    = 1'b0;
   int           hold_left   = 0;

   bresenham_line_rasterizer u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Walk the error term from start to end, queueing every pixel the block should emit
   function automatic void rasterize_line(req_type cmd);
      int      x, y, ex, ey, dx, dy, sx, sy, err, e2, n;
      bit      outside, fin;
      rsp_type pix;
      x   = cmd.start_x;
      y   = cmd.start_y;
      ex  = cmd.end_x;
      ey  = cmd.end_y;
      dx  = (ex > x) ? ex - x : x - ex;
      dy  = (ey > y) ? ey - y : y - ey;
      sx  = (x < ex) ? 1 : -1;
      sy  = (y < ey) ? 1 : -1;
      err = dx - dy;
      n   = 0;
      do begin
         outside = !(x < int'(canvas_w) && y < int'(canvas_h));
         fin     = outside || (x == ex && y == ey) || (n == MAX_SIDE - 1);
         pix.pixel_x       = COORD_W'(x);
         pix.pixel_y       = COORD_W'(y);
         pix.pixel_symbol  = cmd.draw_symbol;
         pix.out_of_canvas = outside;
         pix.last          = fin;
         expected_pixels = {expected_pixels, pix};
         n++;
         e2 = 2 * err;
         if (e2 > -dy) begin
            err -= dy;
            x   += sx;
         end
         if (e2 < dx) begin
            err += dx;
            y   += sy;
         end
      end while (!fin);
   endfunction

   function automatic void report_field(string field, logic [7:0] want, logic [7:0] got);
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      fail_count++;
   endfunction

   function automatic void check_pixel(rsp_type got);
      rsp_type want;
      if (expected_pixels.size() == 0) begin
         $display("%0t: pixel (%0h,%0h) arrived with no line pending", $time,
                  got.pixel_x, got.pixel_y);
         fail_count++;
         return;
      end
      want = expected_pixels.pop_front();
      if (got.pixel_x !== want.pixel_x)
         report_field("pixel_x", 8'(want.pixel_x), 8'(got.pixel_x));
      if (got.pixel_y !== want.pixel_y)
         report_field("pixel_y", 8'(want.pixel_y), 8'(got.pixel_y));
      if (got.pixel_symbol !== want.pixel_symbol)
         report_field("pixel_symbol", want.pixel_symbol, got.pixel_symbol);
      if (got.out_of_canvas !== want.out_of_canvas)
         report_field("out_of_canvas", 8'(want.out_of_canvas), 8'(got.out_of_canvas));
      if (got.last !== want.last)
         report_field("last", 8'(want.last), 8'(got.last));
   endfunction

   // Result side: random stall after every pixel, with calm stretches
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            check_pixel(rsp_data);
            if ($urandom_range(0, 15) == 0)
               rsp_calm = !rsp_calm;
            hold_left = rsp_calm ? 0 : $urandom_range(0, MAX_WAIT);
         end else if (hold_left > 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left != 0);
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL bresenham_line_rasterizer");
         $finish;
      end
   end

   // Present one request after a random gap; returns in the step it is accepted.
   // Valid is left high so a back-to-back request needs no second assignment.
   task automatic issue_line(req_type cmd, logic typed, rsp_type want);
      int gap;
      if ($urandom_range(0, 15) == 0)
         req_calm = !req_calm;
      gap = req_calm ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= cmd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (typed)
         expected_pixels = {expected_pixels, want};
      else
         rasterize_line(cmd);
   endtask

   // Stop requesting and let every queued pixel come out
   task automatic drain_lines();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic program_canvas(logic [CSR_W-1:0] w, logic [CSR_W-1:0] h);
      write_csr(CSR_CANVAS_WIDTH, w);
      write_csr(CSR_SPARE, CSR_W'($urandom_range(0, 127)));
      write_csr(CSR_CANVAS_HEIGHT, h);
      csr_we   <= 1'b0;
      canvas_w = w;
      canvas_h = h;
   endtask

   function automatic logic [CSR_W-1:0] pick_side();
      case ($urandom_range(0, 7))
         0:       return CSR_W'(0);
         1:       return CSR_W'(1);
         2:       return CSR_W'(127);
         3, 4:    return CSR_W'(64);
         default: return CSR_W'($urandom_range(1, 127));
      endcase
   endfunction

   // Half the time keep the start point on a small canvas so lines get drawn
   function automatic logic [COORD_W-1:0] pick_coord(logic [CSR_W-1:0] side);
      if (side > 0 && side < 64 && $urandom_range(0, 1) == 1)
         return COORD_W'($urandom_range(0, side - 1));
      return COORD_W'($urandom_range(0, 63));
   endfunction

   function automatic logic [COORD_W-1:0] nudge(logic [COORD_W-1:0] c);
      int v;
      v = int'(c) + $urandom_range(0, 8) - 4;
      if (v < 0)
         v = 0;
      if (v > 63)
         v = 63;
      return COORD_W'(v);
   endfunction

   function automatic req_type random_line();
      req_type cmd;
      cmd.start_x     = pick_coord(canvas_w);
      cmd.start_y     = pick_coord(canvas_h);
      cmd.draw_symbol = SYM_W'($urandom_range(0, 255));
      case ($urandom_range(0, 9))
         6, 7: begin
            cmd.end_x = nudge(cmd.start_x);
            cmd.end_y = nudge(cmd.start_y);
         end
         8: begin
            cmd.end_x = cmd.start_x;
            cmd.end_y = cmd.start_y;
         end
         9: begin
            cmd.end_x = $urandom_range(0, 1) ? cmd.start_x : pick_coord(canvas_w);
            cmd.end_y = (cmd.end_x == cmd.start_x) ? pick_coord(canvas_h) : cmd.start_y;
         end
         default: begin
            cmd.end_x = COORD_W'($urandom_range(0, 63));
            cmd.end_y = COORD_W'($urandom_range(0, 63));
         end
      endcase
      return cmd;
   endfunction

   // Directed rows checked by the predictor
   function automatic void line_row(int w, int h, int sx, int sy, int ex, int ey, int sym);
      line_row_type r;
      r       = '0;
      r.width = CSR_W'(w);
      r.height = CSR_W'(h);
      r.cmd   = '{COORD_W'(sx), COORD_W'(sy), COORD_W'(ex), COORD_W'(ey), SYM_W'(sym)};
      line_plan = {line_plan, r};
   endfunction

   // Directed rows with one pixel, typed in
   function automatic void dot_row(int w, int h, int sx, int sy, int ex, int ey, int sym,
                                   int wx, int wy, bit woob);
      line_row_type r;
      line_row(w, h, sx, sy, ex, ey, sym);
      r       = line_plan.pop_back();
      r.typed = 1'b1;
      r.want  = '{COORD_W'(wx), COORD_W'(wy), SYM_W'(sym), woob, 1'b1};
      line_plan = {line_plan, r};
   endfunction

   initial begin
      // Reset-size canvas: points, corner-to-corner, edges, shallow and steep
      dot_row (64, 64,  0,  0,  0,  0, 8'h00,  0,  0, 1'b0);
      dot_row (64, 64, 63, 63, 63, 63, 8'hff, 63, 63, 1'b0);
      line_row(64, 64,  0,  0, 63, 63, 8'ha5);
      line_row(64, 64, 63, 63,  0,  0, 8'h5a);
      line_row(64, 64,  0, 63, 63,  0, 8'h3c);
      line_row(64, 64, 63,  0,  0, 63, 8'hc3);
      line_row(64, 64,  0,  0, 63,  0, 8'h2a);
      line_row(64, 64, 63,  5,  0,  5, 8'h55);
      line_row(64, 64,  7,  0,  7, 63, 8'h81);
      line_row(64, 64,  9, 63,  9,  0, 8'h7e);
      line_row(64, 64,  0,  0, 63,  1, 8'h01);
      line_row(64, 64,  2,  0,  0, 63, 8'h80);
      line_row(64, 64, 10, 10, 13, 40, 8'h41);
      // Zero-size canvas: first pixel is already outside
      dot_row ( 0, 64,  5,  5,  9,  9, 8'h23,  5,  5, 1'b1);
      dot_row (64,  0,  0,  0,  3,  3, 8'h24,  0,  0, 1'b1);
      // One-pixel canvas
      dot_row ( 1,  1,  0,  0,  0,  0, 8'h2e,  0,  0, 1'b0);
      line_row( 1,  1,  0,  0,  5,  0, 8'h2d);
      dot_row ( 1,  1,  1,  0,  0,  0, 8'h2b,  1,  0, 1'b1);
      // Canvas larger than any coordinate
      line_row(127, 127, 0, 63, 63,  0, 8'h40);
      dot_row (127, 127, 63, 63, 63, 63, 8'hfe, 63, 63, 1'b0);
      // Runs cut short by the canvas, partway or at the first pixel, then a full-width shallow line
      line_row(32, 16,  0,  0, 63, 63, 8'h2f);
      dot_row (32, 16, 40,  3,  0,  3, 8'h7c, 40,  3, 1'b1);
      line_row(64, 64, 63,  0,  0,  1, 8'h7f);

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (line_plan[i]) begin
         if (line_plan[i].width != canvas_w || line_plan[i].height != canvas_h) begin
            drain_lines();
            program_canvas(line_plan[i].width, line_plan[i].height);
         end
         issue_line(line_plan[i].cmd, line_plan[i].typed, line_plan[i].want);
      end

      // Random lines, one canvas size per phase
      for (int phase = 0; phase < 8; phase++) begin
         drain_lines();
         case (phase)
            0:       program_canvas(64, 64);
            1:       program_canvas(127, 127);
            default: program_canvas(pick_side(), pick_side());
         endcase
         repeat (50) issue_line(random_line(), 1'b0, '0);
      end

      drain_lines();
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("PASS bresenham_line_rasterizer");
      else
         $display("FAIL bresenham_line_rasterizer");
      $finish;
   end

endmodule
